### hdl/gshare_branch_predictor_unit_assert.svh
// Assertion macros used by the predictor RTL.
// Each use samples on the rising edge of clk and is off while arst_n is low.
`ifndef GSHARE_BRANCH_PREDICTOR_UNIT_ASSERT_SVH
`define GSHARE_BRANCH_PREDICTOR_UNIT_ASSERT_SVH

// Property holds in the same cycle.
`define GBP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define GBP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/gbp_pkg.sv
package gbp_pkg;

	// Pattern history table geometry
	localparam int TABLE_ENTRIES = 4096;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CTR_W         = 2;
	localparam logic [CTR_W-1:0] CTR_MAX  = {CTR_W{1'b1}};
	localparam logic [CTR_W-1:0] CTR_HALF = CTR_MAX >> 1;

	// Field widths
	localparam int ADDR_W      = 64;
	localparam int SAVED_W     = 12;
	localparam int SHAMT_W     = 3;
	localparam int IN_DATA_W   = 80;
	localparam int OUT_DATA_W  = 16;
	localparam logic [SHAMT_W-1:0] SHAMT_RESET = 3'd2;

	// Operation codes carried in tuser
	typedef enum logic [2:0] {
		FUNC_LOOKUP = 3'd0,
		FUNC_UNCOND = 3'd1,
		FUNC_BTB    = 3'd2,
		FUNC_UPDATE = 3'd3,
		FUNC_SQUASH = 3'd4
	} func_t;

	// Status of the post-reset table clearing sweep
	typedef struct packed {
		logic             active;
		logic [IDX_W-1:0] addr;
	} sweep_t;

endpackage

### hdl/gshare_branch_predictor_unit.sv
// Channel  Direction  Handshake           Payload
// s_       in         s_tvalid/s_tready   tuser: func; tdata: branch_addr, taken, squashed,
//                                         has_record, saved_history
// m_       out        m_tvalid/m_tready   tdata: prediction, history_snapshot
// cfg_     in         cfg_valid/cfg_ready data: inst_shift_amt
//
// For an item, the transfer cycle issues the counter read; the second stage then
// computes the prediction, writes the counter back and updates history.
// The result sits in an output register; a new item is taken while it waits.
// After reset a sweep clears the 4096-entry counter table, one entry per cycle, and
// s_tready stays low until the sweep ends. Configuration writes are always taken.
// A stalled output holds the second stage, which holds off the input side.
module gshare_branch_predictor_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [63:0] branch_addr, [64] taken, [65] squashed, [66] has_record,
	// [78:67] saved_history, [79] zero
	input  logic [gbp_pkg::IN_DATA_W-1:0]     s_tdata,
	// [2:0] func
	input  logic [2:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [0] prediction, [12:1] history_snapshot, [15:13] zero
	output logic [gbp_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [gbp_pkg::SHAMT_W-1:0]       cfg_data
);

	`include "gshare_branch_predictor_unit_assert.svh"

	localparam int IW = gbp_pkg::IDX_W;
	localparam int CW = gbp_pkg::CTR_W;

	gbp_pkg::sweep_t sweep;

	logic [gbp_pkg::SHAMT_W-1:0] shamt_q;
	logic [IW-1:0]               hist_q;

	logic                  busy_s1;
	gbp_pkg::func_t        func_s1;
	logic                  taken_s1;
	logic                  squashed_s1;
	logic                  rec_s1;
	logic [IW-1:0]         saved_s1;
	logic [IW-1:0]         idx_s1;

	logic                  m_tvalid_q;
	logic [gbp_pkg::OUT_DATA_W-1:0] m_tdata_q;

	logic                  in_xfer;
	logic                  s1_done;
	gbp_pkg::func_t        in_func;
	logic [gbp_pkg::ADDR_W-1:0] addr_shift;
	logic [IW-1:0]         in_saved;
	logic [IW-1:0]         in_idx;

	logic [CW-1:0]         ctr_rd;
	logic [CW-1:0]         ctr_nxt;
	logic                  pred;
	logic                  ctr_wr;
	logic [IW-1:0]         hist_nxt;

	logic                  ram_en;
	logic                  ram_we;
	logic [IW-1:0]         ram_addr;
	logic [CW-1:0]         ram_wdata;

	gbp_sweep u_sweep (
		.clk    (clk),
		.arst_n (arst_n),
		.sweep  (sweep)
	);

	// Input side: one item in flight at a time
	assign s_tready  = !sweep.active && !busy_s1;
	assign in_xfer   = s_tvalid && s_tready;
	assign s1_done   = busy_s1 && (!m_tvalid_q || m_tready);
	assign cfg_ready = 1'b1;

	// Hash the shifted address with live or saved history
	assign in_func    = gbp_pkg::func_t'(s_tuser[2:0]);
	assign addr_shift = s_tdata[gbp_pkg::ADDR_W-1:0] >> shamt_q;
	assign in_saved   = s_tdata[67 +: IW];
	assign in_idx     = addr_shift[IW-1:0] ^
		((in_func == gbp_pkg::FUNC_LOOKUP) ? hist_q : in_saved);

	// Predict from the counter, move it toward the outcome and form the next history
	always_comb begin
		pred    = 1'b0;
		ctr_nxt = ctr_rd;
		ctr_wr  = 1'b0;
		hist_nxt = hist_q;
		case (func_s1)
			gbp_pkg::FUNC_LOOKUP: begin
				pred     = ctr_rd > gbp_pkg::CTR_HALF;
				hist_nxt = {hist_q[IW-2:0], pred};
			end
			gbp_pkg::FUNC_UNCOND: begin
				pred     = 1'b1;
				hist_nxt = {hist_q[IW-2:0], 1'b1};
			end
			gbp_pkg::FUNC_BTB: begin
				hist_nxt = {hist_q[IW-1:1], 1'b0};
			end
			gbp_pkg::FUNC_UPDATE: begin
				if (rec_s1) begin
					ctr_wr = 1'b1;
					if (taken_s1) begin
						if (ctr_rd != gbp_pkg::CTR_MAX) begin
							ctr_nxt = ctr_rd + 1'b1;
						end
					end else if (ctr_rd != '0) begin
						ctr_nxt = ctr_rd - 1'b1;
					end
					if (squashed_s1) begin
						hist_nxt = {saved_s1[IW-2:0], taken_s1};
					end
				end
			end
			gbp_pkg::FUNC_SQUASH: begin
				hist_nxt = saved_s1;
			end
			default: begin
				hist_nxt = hist_q;
			end
		endcase
	end

	// Table port: sweep write, else write-back, else counter read for an accepted item
	always_comb begin
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = idx_s1;
		ram_wdata = ctr_nxt;
		if (sweep.active) begin
			ram_en    = 1'b1;
			ram_we    = 1'b1;
			ram_addr  = sweep.addr;
			ram_wdata = '0;
		end else if (s1_done && ctr_wr) begin
			ram_en = 1'b1;
			ram_we = 1'b1;
		end else if (in_xfer) begin
			ram_en   = 1'b1;
			ram_addr = in_idx;
		end
	end

	gbp_ram #(
		.WIDTH (CW),
		.DEPTH (gbp_pkg::TABLE_ENTRIES)
	) u_pht (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ctr_rd)
	);

	// Control state: shift amount, history, stage and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shamt_q    <= gbp_pkg::SHAMT_RESET;
			hist_q     <= '0;
			busy_s1    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				shamt_q <= cfg_data;
			end
			if (s1_done) begin
				hist_q <= hist_nxt;
			end
			if (in_xfer) begin
				busy_s1 <= 1'b1;
			end else if (s1_done) begin
				busy_s1 <= 1'b0;
			end
			if (s1_done) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Payload of the second stage
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			func_s1     <= in_func;
			taken_s1    <= s_tdata[64];
			squashed_s1 <= s_tdata[65];
			rec_s1      <= s_tdata[66];
			saved_s1    <= in_saved;
			idx_s1      <= in_idx;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (s1_done) begin
			m_tdata_q <= {{(gbp_pkg::OUT_DATA_W - IW - 1){1'b0}}, hist_q, pred};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`GBP_ASSERT(a_no_xfer_in_sweep, !(in_xfer && sweep.active), "input taken during sweep")
	`GBP_ASSERT(a_rmw_interlock, !(in_xfer && busy_s1), "read overlaps pending write-back")
	`GBP_ASSERT_NEXT(a_xfer_fills_s1, in_xfer, busy_s1 && !s1_done || busy_s1,
		"accepted item not held in stage")
	`GBP_ASSERT_NEXT(a_done_gives_result, s1_done, m_tvalid, "finished item lost")

endmodule

### hdl/gbp_ram.sv
module gbp_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single port, registered read
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

### hdl/gbp_sweep.sv
module gbp_sweep (
	input  logic           clk,
	input  logic           arst_n,
	output gbp_pkg::sweep_t sweep
);

	logic                    active_q;
	logic [gbp_pkg::IDX_W-1:0] addr_q;

	// Walk every table entry once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b1;
			addr_q   <= '0;
		end else if (active_q) begin
			addr_q <= addr_q + 1'b1;
			if (addr_q == {gbp_pkg::IDX_W{1'b1}}) begin
				active_q <= 1'b0;
			end
		end
	end

	assign sweep.active = active_q;
	assign sweep.addr   = addr_q;

endmodule
